// File: hw/rtl/osrtm_pkg.sv
// Shared types and constants for the one-shot rectangle trigger matcher.
`timescale 1ns / 1ps
`default_nettype none

package osrtm_pkg;

    localparam int MAX_REGIONS_DEFAULT = 32;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_MASK  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_TABLE_PRESENT = 2'd0;
    localparam logic [1:0] REG_REGION_COUNT  = 2'd1;

    localparam int CFG_DATA_W = 6;
    localparam int ROUTE_BIT  = 15;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         region_index;
        logic [15:0]        x_low;
        logic [15:0]        z_low;
        logic [15:0]        x_high;
        logic [15:0]        z_high;
        logic [15:0]        command_word;
        logic [31:0]        mask_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } t_in;

    typedef struct packed {
        logic        fired;
        logic [4:0]  hit_index;
        logic [15:0] hit_command;
        logic        route;
        logic [15:0] point_x;
        logic [15:0] point_z;
    } t_out;

    typedef struct packed {
        logic [15:0] command_word;
        logic [15:0] z_high;
        logic [15:0] x_high;
        logic [15:0] z_low;
        logic [15:0] x_low;
    } t_region;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_run;
        logic take_hit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/osrtm_ctrl.sv
// Controller state machine of the trigger matcher: handshakes and scan sequencing.
`timescale 1ns / 1ps
`default_nettype none

module osrtm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_kind,
    input  wire logic              i_out_ready,
    input  wire osrtm_pkg::t_status i_status,
    output osrtm_pkg::t_cmd        o_cmd,
    output logic                   o_in_ready,
    output logic                   o_out_valid
);
    import osrtm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = (i_kind == KIND_CHECK) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                priority if (i_status.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.miss) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an untaken transaction");

endmodule

`default_nettype wire

// File: hw/rtl/osrtm_dp.sv
// Datapath of the trigger matcher: region table, fired mask, scan compare and result.
`timescale 1ns / 1ps
`default_nettype none

module osrtm_dp #(
    parameter int MAX_REGIONS = osrtm_pkg::MAX_REGIONS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire osrtm_pkg::t_in                       i_in,
    input  wire osrtm_pkg::t_cmd                      i_cmd,
    input  wire logic                                 i_cfg_we,
    input  wire logic [1:0]                           i_cfg_idx,
    input  wire logic [osrtm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output osrtm_pkg::t_status                        o_status,
    output osrtm_pkg::t_out                           o_out
);
    import osrtm_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic                   r_table_present;
    logic [5:0]             r_region_count;
    logic [MAX_REGIONS-1:0] r_fired;
    t_region                r_mem [MAX_REGIONS];
    t_region                r_rd_entry;
    logic [CW-1:0]          r_rd_idx;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_cmp_vld;
    logic [15:0]            r_pt_x;
    logic [15:0]            r_pt_z;
    t_out                   r_res;
    t_out                   r_out;

    logic [CW-1:0] scan_len;
    logic          issue;
    logic          inside_box;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_present <= 1'b0;
            r_region_count  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TABLE_PRESENT) begin
                r_table_present <= i_cfg_data[0];
            end else if (i_cfg_idx == REG_REGION_COUNT) begin
                r_region_count <= i_cfg_data[5:0];
            end
        end
    end

    always_comb begin
        if (!r_table_present) begin
            scan_len = '0;
        end else if (32'(r_region_count) > MAX_REGIONS) begin
            scan_len = CW'(MAX_REGIONS);
        end else begin
            scan_len = CW'(r_region_count);
        end
    end

    assign issue = i_cmd.scan_run && (r_rd_idx < scan_len);

    // Region table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_in.kind == KIND_WRITE
                && 32'(i_in.region_index) < MAX_REGIONS) begin
            r_mem[i_in.region_index[IW-1:0]] <= '{
                command_word: i_in.command_word,
                z_high:       i_in.z_high,
                x_high:       i_in.x_high,
                z_low:        i_in.z_low,
                x_low:        i_in.x_low};
        end
        if (issue) begin
            r_rd_entry <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    // Scan counters: the read runs one entry ahead of the compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_run) begin
            r_cmp_vld <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
    end

    assign inside_box = (r_pt_x >= r_rd_entry.x_low) && (r_pt_x <= r_rd_entry.x_high)
                     && (r_pt_z >= r_rd_entry.z_low) && (r_pt_z <= r_rd_entry.z_high);

    assign o_status.hit  = r_cmp_vld && !r_fired[r_cmp_idx] && inside_box;
    assign o_status.miss = !r_cmp_vld && (r_rd_idx >= scan_len);

    // Fired mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fired <= '0;
        end else if (i_cmd.accept && i_in.kind == KIND_MASK) begin
            r_fired <= i_in.mask_value[MAX_REGIONS-1:0];
        end else if (i_cmd.take_hit) begin
            r_fired[r_cmp_idx] <= 1'b1;
        end
    end

    // Point capture, result build and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pt_x <= i_in.pos_x[23:8];
            r_pt_z <= i_in.pos_z[23:8];
            r_res  <= '{
                fired:       1'b0,
                hit_index:   5'd0,
                hit_command: 16'h0000,
                route:       1'b0,
                point_x:     (i_in.kind == KIND_CHECK) ? i_in.pos_x[23:8] : 16'h0000,
                point_z:     (i_in.kind == KIND_CHECK) ? i_in.pos_z[23:8] : 16'h0000};
        end else if (i_cmd.take_hit) begin
            r_res.fired       <= 1'b1;
            r_res.hit_index   <= 5'(r_cmp_idx);
            r_res.hit_command <= r_rd_entry.command_word;
            r_res.route       <= r_rd_entry.command_word[ROUTE_BIT];
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out = r_out;

    a_hit_marks_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |=> r_fired[$past(r_cmp_idx)])
        else $error("fired region not recorded in mask");

    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |=> (r_res.fired && r_res.hit_index == 5'($past(r_cmp_idx))))
        else $error("result index does not match the compared entry");

    a_no_hit_when_unfired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |-> r_cmp_vld)
        else $error("hit taken without a compared entry");

endmodule

`default_nettype wire

// File: hw/rtl/one_shot_rectangle_trigger_matcher_top.sv
// Top level of the one-shot rectangle trigger matcher.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The input channel (i_in, i_in_valid, o_in_ready) takes one transaction per
// item: kind 0 writes a region entry, kind 1 loads the fired mask and kind 2
// checks an actor position. Every input transaction yields exactly one result
// transaction on the output channel (o_out, o_out_valid, i_out_ready).
// A check scans regions from index 0 upward through one registered read port
// of the region table, one entry per cycle, and stops at the first unfired
// region that holds the point. With no table or a count of zero it scans no
// entry. Writes, mask loads and unused kinds skip the scan. The block works
// on one item at a time and takes the next item once the result enters the
// output register, even if that result is not yet taken. When the receiver
// stalls, the result waits in the output register and a following result
// waits in the datapath until the register frees up. Reset clears the fired
// mask, both configuration registers and all control state; the region table
// is not cleared and must be written before it is scanned. Configuration
// writes on i_cfg_we take effect at once and must only be issued while no
// transaction is in flight.
module one_shot_rectangle_trigger_matcher_top #(
    parameter int MAX_REGIONS = osrtm_pkg::MAX_REGIONS_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire osrtm_pkg::t_in                   i_in,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    output osrtm_pkg::t_out                       o_out,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic                             i_cfg_we,
    input  wire logic [1:0]                       i_cfg_idx,
    input  wire logic [osrtm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import osrtm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller sequences the handshakes and the scan.
    osrtm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in.kind),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // The datapath holds the table, the mask and the result registers.
    osrtm_dp #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire
